// ===== rtl/ehp_pkg.sv =====
// Package for the EBML element header parser: widths, result type and lead-bit decode.
`default_nettype none
package ehp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned IdW      = 32;
  localparam int unsigned IdLenW   = 3;
  localparam int unsigned SizeW    = 56;
  localparam int unsigned SizeLenW = 4;
  localparam int unsigned LeftW    = 3;

  // Longest legal ID in bytes and the size length that carries the unknown code.
  localparam logic [SizeLenW-1:0] MaxIdLen       = 4'd4;
  localparam logic [SizeLenW-1:0] UnknownSizeLen = 4'd8;

  typedef struct packed {
    logic [IdW-1:0]      ebml_id;
    logic [IdLenW-1:0]   id_length;
    logic [SizeW-1:0]    payload_size;
    logic [SizeLenW-1:0] size_length;
    logic                size_unknown;
    logic                id_error;
  } ehp_result_t;

  // Position (1..8) of the leading one bit counted from the MSB, 0 for a zero byte.
  function automatic logic [SizeLenW-1:0] ehp_lead_len(input logic [ByteW-1:0] b);
    logic [SizeLenW-1:0] n;
    n = '0;
    for (int i = 0; i < ByteW; i++) begin
      if (b[i]) begin
        n = SizeLenW'(ByteW - i);
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ehp_byte_if.sv =====
// Handshake channel carrying one stream byte and its restart flag.
`default_nettype none
interface ehp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface
`default_nettype wire

// ===== rtl/ehp_header_if.sv =====
// Handshake channel carrying one parsed element header.
`default_nettype none
interface ehp_header_if;
  logic        valid;
  logic        ready;
  logic [31:0] ebml_id;
  logic [2:0]  id_length;
  logic [55:0] payload_size;
  logic [3:0]  size_length;
  logic        size_unknown;
  logic        id_error;

  modport source (output valid, output ebml_id, output id_length, output payload_size,
                  output size_length, output size_unknown, output id_error, input ready);
  modport sink   (input valid, input ebml_id, input id_length, input payload_size,
                  input size_length, input size_unknown, input id_error, output ready);
endinterface
`default_nettype wire

// ===== rtl/ebml_element_header_parser_unit.sv =====
// EBML element header parser: ID and variable-length size decode from a byte stream.
// Throughput: one byte per cycle, sustained, as long as the header side takes results.
// The header is registered and appears on the output in the cycle after its last byte is accepted.
// A waiting header holds off the byte input until it is taken; a byte enters in that cycle.
// Reset (rst, synchronous) clears the parse state and drops any pending result.
`default_nettype none
module ebml_element_header_parser_unit (
  input  wire logic   clk,
  input  wire logic   rst,
  ehp_byte_if.sink    stream,
  ehp_header_if.source header
);
  import ehp_pkg::*;

  logic                phase;
  logic [LeftW-1:0]    bytes_left;
  logic [IdW-1:0]      id_accum;
  logic [IdLenW-1:0]   id_len_seen;
  logic [SizeW-1:0]    size_accum;
  logic [SizeLenW-1:0] size_len_seen;

  logic                phase_next;
  logic [LeftW-1:0]    bytes_left_next;
  logic [IdW-1:0]      id_accum_next;
  logic [IdLenW-1:0]   id_len_seen_next;
  logic [SizeW-1:0]    size_accum_next;
  logic [SizeLenW-1:0] size_len_seen_next;

  logic                ph;
  logic [LeftW-1:0]    bl;
  logic [IdW-1:0]      ida;
  logic [IdLenW-1:0]   idl;
  logic [SizeW-1:0]    sza;
  logic [SizeLenW-1:0] szl;

  logic [SizeLenW-1:0] lead;
  logic                fire;
  logic                emit;
  logic                clear;
  ehp_result_t         res_next;
  ehp_result_t         res;
  logic                res_valid;
  logic                accept;
  logic [ByteW-1:0]    lead_mask;

  assign stream.ready = !res_valid || header.ready;
  assign accept       = stream.valid && stream.ready;
  assign lead         = ehp_lead_len(stream.data_byte);
  assign lead_mask    = 8'hFF >> lead;

  always_comb begin
    // Restart drops the partial header before the byte is looked at.
    ph  = stream.restart ? 1'b0 : phase;
    bl  = stream.restart ? '0 : bytes_left;
    ida = stream.restart ? '0 : id_accum;
    idl = stream.restart ? '0 : id_len_seen;
    sza = stream.restart ? '0 : size_accum;
    szl = stream.restart ? '0 : size_len_seen;

    phase_next         = ph;
    bytes_left_next    = bl;
    id_accum_next      = ida;
    id_len_seen_next   = idl;
    size_accum_next    = sza;
    size_len_seen_next = szl;
    fire               = 1'b0;
    emit               = 1'b0;
    clear              = 1'b0;
    res_next           = '0;

    if (!ph) begin
      if (idl == '0) begin
        if (lead == '0 || lead > MaxIdLen) begin
          fire              = 1'b1;
          clear             = 1'b1;
          res_next.id_error = 1'b1;
        end else begin
          id_accum_next    = IdW'(stream.data_byte);
          id_len_seen_next = lead[IdLenW-1:0];
          bytes_left_next  = LeftW'(lead - 4'd1);
          phase_next       = (lead == 4'd1);
        end
      end else begin
        id_accum_next   = {ida[IdW-ByteW-1:0], stream.data_byte};
        bytes_left_next = bl - 3'd1;
        phase_next      = (bl == 3'd1);
      end
    end else begin
      if (szl == '0) begin
        if (lead == '0) begin
          // A size lead byte without a marker closes the header with no size.
          fire               = 1'b1;
          clear              = 1'b1;
          res_next.ebml_id   = ida;
          res_next.id_length = idl;
        end else begin
          size_accum_next    = SizeW'(stream.data_byte & lead_mask);
          size_len_seen_next = lead;
          bytes_left_next    = LeftW'(lead - 4'd1);
          emit               = (lead == 4'd1);
        end
      end else begin
        size_accum_next = {sza[SizeW-ByteW-1:0], stream.data_byte};
        bytes_left_next = bl - 3'd1;
        emit            = (bl == 3'd1);
      end
    end

    if (emit) begin
      fire                  = 1'b1;
      clear                 = 1'b1;
      res_next.ebml_id      = id_accum_next;
      res_next.id_length    = id_len_seen_next;
      res_next.size_length  = size_len_seen_next;
      res_next.size_unknown = (size_len_seen_next == UnknownSizeLen) && (&size_accum_next);
      res_next.payload_size = res_next.size_unknown ? '0 : size_accum_next;
    end

    if (clear) begin
      phase_next         = 1'b0;
      bytes_left_next    = '0;
      id_accum_next      = '0;
      id_len_seen_next   = '0;
      size_accum_next    = '0;
      size_len_seen_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= 1'b0;
      bytes_left    <= '0;
      id_accum      <= '0;
      id_len_seen   <= '0;
      size_accum    <= '0;
      size_len_seen <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (accept) begin
        phase         <= phase_next;
        bytes_left    <= bytes_left_next;
        id_accum      <= id_accum_next;
        id_len_seen   <= id_len_seen_next;
        size_accum    <= size_accum_next;
        size_len_seen <= size_len_seen_next;
      end
      if (accept && fire) begin
        res_valid <= 1'b1;
      end else if (header.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && fire) begin
      res <= res_next;
    end
  end

  assign header.valid        = res_valid;
  assign header.ebml_id      = res.ebml_id;
  assign header.id_length    = res.id_length;
  assign header.payload_size = res.payload_size;
  assign header.size_length  = res.size_length;
  assign header.size_unknown = res.size_unknown;
  assign header.id_error     = res.id_error;

  // An ID error transaction carries nothing but the error flag.
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    header.valid && header.id_error |->
      header.ebml_id == '0 && header.id_length == '0 && header.size_length == '0)
    else $error("id error result carries header fields");

  // The unknown code only comes from an eight-byte size and reports a zero size.
  a_unknown_size: assert property (@(posedge clk) disable iff (rst)
    header.valid && header.size_unknown |->
      header.size_length == UnknownSizeLen && header.payload_size == '0)
    else $error("unknown size flag with wrong size fields");

  // No size bytes are gathered before the ID is complete.
  a_phase_order: assert property (@(posedge clk) disable iff (rst)
    !phase |-> size_len_seen == '0)
    else $error("size state set while parsing the ID");

  // A stalled result blocks the input so that no header is overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    header.valid && !header.ready |=> header.valid)
    else $error("pending header dropped");

endmodule
`default_nettype wire

// ===== verif/tb_ebml_element_header_parser_unit.sv =====
// Testbench for the EBML element header parser: directed byte table, then random streams.
`timescale 1ns / 100ps
module tb_ebml_element_header_parser_unit;
  import ehp_pkg::*;

  localparam int unsigned NumRandom   = 1950;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned HoldAt      = 40;
  localparam int unsigned DrainCycles = 20;

  typedef struct {
    logic [7:0]  data;
    logic        restart;
    bit          typed;
    ehp_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ehp_byte_if   byte_ch ();
  ehp_header_if hdr_ch ();

  ebml_element_header_parser_unit dut (
    .clk    (clk),
    .rst    (rst),
    .stream (byte_ch),
    .header (hdr_ch)
  );

  always #2 clk = ~clk;

  // Parse state of the header model.
  bit          in_size;
  logic [2:0]  left_cnt;
  logic [31:0] id_acc;
  logic [2:0]  id_len;
  logic [55:0] size_acc;
  logic [3:0]  size_len;

  stim_row_t   byte_table[$];
  ehp_result_t expected_headers[$];
  int unsigned directed_rows;
  int unsigned headers_taken;
  bit          failed;

  function automatic void clear_parse();
    in_size  = 1'b0;
    left_cnt = '0;
    id_acc   = '0;
    id_len   = '0;
    size_acc = '0;
    size_len = '0;
  endfunction

  // Length encoded by a lead byte: position of its first set bit from the top, 0 if none.
  function automatic int unsigned marker_pos(input logic [7:0] b);
    for (int k = 7; k >= 0; k--) begin
      if (b[k]) return 8 - k;
    end
    return 0;
  endfunction

  // Advances the header model by one byte; returns 1 when a header result is due.
  function automatic bit parse_byte(input logic [7:0] b, input logic rs,
                                    output ehp_result_t hdr);
    int unsigned n;
    hdr = '0;
    if (rs) clear_parse();
    if (!in_size) begin
      if (id_len == 0) begin
        n = marker_pos(b);
        if (n == 0 || n > MaxIdLen) begin
          clear_parse();
          hdr.id_error = 1'b1;
          return 1'b1;
        end
        id_acc   = {24'h0, b};
        id_len   = 3'(n);
        left_cnt = 3'(n - 1);
      end else begin
        id_acc   = {id_acc[23:0], b};
        left_cnt = left_cnt - 3'd1;
      end
      if (left_cnt == 0) in_size = 1'b1;
      return 1'b0;
    end
    if (size_len == 0) begin
      n = marker_pos(b);
      if (n == 0) begin
        // A size lead byte with no marker ends the header with what was gathered.
        hdr.ebml_id   = id_acc;
        hdr.id_length = id_len;
        clear_parse();
        return 1'b1;
      end
      size_acc = 56'(b & (8'hFF >> n));
      size_len = 4'(n);
      left_cnt = 3'(n - 1);
    end else begin
      size_acc = {size_acc[47:0], b};
      left_cnt = left_cnt - 3'd1;
    end
    if (left_cnt != 0) return 1'b0;
    hdr.ebml_id     = id_acc;
    hdr.id_length   = id_len;
    hdr.size_length = size_len;
    if (size_len == UnknownSizeLen && &size_acc) begin
      hdr.size_unknown = 1'b1;
    end else begin
      hdr.payload_size = size_acc;
    end
    clear_parse();
    return 1'b1;
  endfunction

  function automatic ehp_result_t header_of(input logic [31:0] id, input logic [2:0] idl,
                                            input logic [55:0] sz, input logic [3:0] szl,
                                            input logic unk, input logic err);
    return '{ebml_id: id, id_length: idl, payload_size: sz, size_length: szl,
             size_unknown: unk, id_error: err};
  endfunction

  function automatic void add_row(input logic [7:0] d, input logic rs, input bit typed,
                                  input ehp_result_t want);
    stim_row_t row;
    row.data    = d;
    row.restart = rs;
    row.typed   = typed;
    row.want    = want;
    byte_table.push_back(row);
  endfunction

  // Appends one header with random content; keep cuts it short, zero_size ends it
  // with a size lead byte that carries no marker.
  function automatic void add_header(input logic rs, input int unsigned keep,
                                     input bit zero_size);
    int unsigned idn;
    int unsigned szn;
    int unsigned total;
    bit          ones;
    logic [7:0]  hb[12];
    idn  = $urandom_range(1, 4);
    szn  = $urandom_range(1, 8);
    ones = ($urandom_range(0, 5) == 0);
    hb[0] = (8'h80 >> (idn - 1)) | (8'($urandom) & (8'hFF >> idn));
    for (int k = 1; k < idn; k++) hb[k] = 8'($urandom);
    if (zero_size) begin
      hb[idn] = 8'h00;
      total   = idn + 1;
    end else begin
      hb[idn] = (8'h80 >> (szn - 1)) |
                (ones ? (8'hFF >> szn) : (8'($urandom) & (8'hFF >> szn)));
      for (int k = 1; k < szn; k++) hb[idn + k] = ones ? 8'hFF : 8'($urandom);
      total = idn + szn;
    end
    if (keep != 0 && keep < total) total = keep;
    for (int k = 0; k < total; k++) add_row(hb[k], (k == 0) ? rs : 1'b0, 1'b0, '0);
  endfunction

  function automatic void build_table();
    int unsigned pick;
    logic        rs;
    bit          need_restart;
    // Lead bytes without a marker in the top four bits.
    add_row(8'h00, 1'b0, 1'b1, header_of(32'h0, 3'd0, 56'h0, 4'd0, 1'b0, 1'b1));
    add_row(8'h0F, 1'b0, 1'b1, header_of(32'h0, 3'd0, 56'h0, 4'd0, 1'b0, 1'b1));
    add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, '0);
    // Four-byte ID with the eight-byte all-ones size code.
    add_row(8'h1A, 1'b0, 1'b0, '0);
    add_row(8'h45, 1'b0, 1'b0, '0);
    add_row(8'hDF, 1'b0, 1'b0, '0);
    add_row(8'hA3, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, '0);
    for (int k = 0; k < 6; k++) add_row(8'hFF, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b1, header_of(32'h1A45DFA3, 3'd4, 56'h0, 4'd8, 1'b1, 1'b0));
    // Size lead byte of zero.
    add_row(8'h42, 1'b0, 1'b0, '0);
    add_row(8'h86, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b1, header_of(32'h4286, 3'd2, 56'h0, 4'd0, 1'b0, 1'b0));
    // Restart in the middle of an ID, then restart with nothing pending.
    add_row(8'h3F, 1'b0, 1'b0, '0);
    add_row(8'h12, 1'b0, 1'b0, '0);
    add_row(8'h81, 1'b1, 1'b0, '0);
    add_row(8'h80, 1'b0, 1'b0, '0);
    add_row(8'h20, 1'b1, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, '0);
    add_row(8'h7F, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b1, header_of(32'h200000, 3'd3, 56'h3FFF, 4'd2, 1'b0, 1'b0));
    directed_rows = byte_table.size();

    need_restart = 1'b0;
    while (byte_table.size() < directed_rows + NumRandom) begin
      pick = $urandom_range(0, 99);
      rs   = need_restart | ($urandom_range(0, 9) == 0);
      need_restart = 1'b0;
      if (pick < 78) begin
        add_header(rs, 0, 1'b0);
      end else if (pick < 85) begin
        add_row(8'($urandom_range(0, 15)), rs, 1'b0, '0);
      end else if (pick < 90) begin
        add_header(rs, 0, 1'b1);
      end else if (pick < 96) begin
        add_header(rs, $urandom_range(1, 11), 1'b0);
        need_restart = 1'b1;
      end else begin
        add_row(8'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
        need_restart = 1'b1;
      end
    end
  endfunction

  // Byte source, predictor and end of run.
  initial begin
    int unsigned gap;
    bit          tx_burst;
    bit          due;
    ehp_result_t hdr;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.restart   = 1'b0;
    clear_parse();
    build_table();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (byte_table[i]) begin
      if (i % 64 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      gap = tx_burst ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
        byte_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      byte_ch.valid     = 1'b1;
      byte_ch.data_byte = byte_table[i].data;
      byte_ch.restart   = byte_table[i].restart;
      do @(posedge clk); while (!byte_ch.ready);
      due = parse_byte(byte_table[i].data, byte_table[i].restart, hdr);
      if (byte_table[i].typed) begin
        expected_headers.push_back(byte_table[i].want);
      end else if (due) begin
        expected_headers.push_back(hdr);
      end
      @(negedge clk);
    end
    byte_ch.valid = 1'b0;
    wait (expected_headers.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (!failed && expected_headers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Header sink with random stalls and one long hold that backs up the stream side.
  initial begin
    int unsigned stall;
    bit          rx_burst;
    hdr_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (headers_taken % 50 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      stall = rx_burst ? 0 : $urandom_range(0, 14);
      if (headers_taken == HoldAt) stall = HoldCycles;
      if (stall != 0) begin
        hdr_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      hdr_ch.ready = 1'b1;
      do @(posedge clk); while (!hdr_ch.valid);
    end
  end

  always @(posedge clk) begin : check_headers
    ehp_result_t want;
    if (!rst && hdr_ch.valid && hdr_ch.ready) begin
      headers_taken++;
      if (expected_headers.size() == 0) begin
        $error("unexpected header transaction: ebml_id %h", hdr_ch.ebml_id);
        failed = 1'b1;
      end else begin
        want = expected_headers.pop_front();
        if (hdr_ch.ebml_id !== want.ebml_id) begin
          $error("ebml_id: expected %h, got %h", want.ebml_id, hdr_ch.ebml_id);
          failed = 1'b1;
        end
        if (hdr_ch.id_length !== want.id_length) begin
          $error("id_length: expected %0d, got %0d", want.id_length, hdr_ch.id_length);
          failed = 1'b1;
        end
        if (hdr_ch.payload_size !== want.payload_size) begin
          $error("payload_size: expected %h, got %h", want.payload_size,
                 hdr_ch.payload_size);
          failed = 1'b1;
        end
        if (hdr_ch.size_length !== want.size_length) begin
          $error("size_length: expected %0d, got %0d", want.size_length, hdr_ch.size_length);
          failed = 1'b1;
        end
        if (hdr_ch.size_unknown !== want.size_unknown) begin
          $error("size_unknown: expected %b, got %b", want.size_unknown, hdr_ch.size_unknown);
          failed = 1'b1;
        end
        if (hdr_ch.id_error !== want.id_error) begin
          $error("id_error: expected %b, got %b", want.id_error, hdr_ch.id_error);
          failed = 1'b1;
        end
      end
    end
  end

  // Ends the run when neither side has completed a transaction for too long.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    wait (!rst);
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if ((byte_ch.valid && byte_ch.ready) || (hdr_ch.valid && hdr_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAILURE");
    $finish;
  end

endmodule
